// File: sv/dps_pkg.sv
// shared types and constants for the discharge pulse sequencer
package dps_pkg;

	localparam int unsigned CFG_BITS = 20;

	// sequencer phase codes
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_OFF  = 2'd1;
	localparam logic [1:0] PH_WAIT = 2'd2;
	localparam logic [1:0] PH_ON   = 2'd3;

	// item operation codes
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_START = 1'b1;

	// register indexes on the configuration port
	localparam logic [1:0] REG_ON_TICKS  = 2'd0;
	localparam logic [1:0] REG_OFF_TICKS = 2'd1;
	localparam logic [1:0] REG_ISO_MODE  = 2'd2;

	localparam logic [3:0]          INRUSH_TICKS = 4'd15;
	localparam logic [CFG_BITS-1:0] TURN_ON_LEAD = 20'd11;

	typedef struct packed {
		logic op;
		logic trip_edge;
		logic cut_enable;
	} item_t;

	typedef struct packed {
		logic       fet_on;
		logic       charger_on;
		logic       charger_inrush_limit;
		logic [1:0] phase;
	} result_t;

	typedef struct packed {
		logic [CFG_BITS-1:0] on_ticks;
		logic [CFG_BITS-1:0] off_ticks;
		logic                iso_mode;
	} cfg_t;

endpackage

// File: sv/dps_seq.sv
// phase state machine, phase and inrush counters, next-state result
module dps_seq #(
	parameter int unsigned TIME_BITS = 20
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  dps_pkg::item_t   item,
	input  dps_pkg::cfg_t    cfg,
	output dps_pkg::result_t result
);
	import dps_pkg::*;

	localparam int unsigned LW = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;
	localparam logic [LW-1:0]        CMAX_L = LW'((64'd1 << TIME_BITS) - 64'd1);
	localparam logic [TIME_BITS-1:0] CMAX_T = {TIME_BITS{1'b1}};

	logic [1:0]           phase_q, phase_d;
	logic [TIME_BITS-1:0] count_q, count_d, count_inc;
	logic [3:0]           inrush_cnt_q, inrush_cnt_d, inrush_cnt_inc;
	logic                 fet_q, fet_d;
	logic                 chg_q, chg_d;
	logic                 inr_q, inr_d;

	logic [CFG_BITS-1:0] off_raw;
	logic [LW-1:0]       off_lim, on_lim, half_lim, off_ext, on_ext, half_ext, count_ext;

	always_comb begin
		off_raw  = (cfg.off_ticks > TURN_ON_LEAD) ? cfg.off_ticks - TURN_ON_LEAD : '0;
		off_ext  = LW'(off_raw);
		on_ext   = LW'(cfg.on_ticks);
		half_ext = LW'(cfg.on_ticks >> 1);
		off_lim  = (off_ext > CMAX_L) ? CMAX_L : off_ext;
		on_lim   = (on_ext > CMAX_L) ? CMAX_L : on_ext;
		half_lim = (half_ext > CMAX_L) ? CMAX_L : half_ext;
	end

	always_comb begin
		count_inc      = (count_q == CMAX_T) ? count_q : count_q + TIME_BITS'(1);
		count_ext      = LW'(count_inc);
		inrush_cnt_inc = inrush_cnt_q + 4'd1;
	end

	always_comb begin
		phase_d      = phase_q;
		count_d      = count_q;
		inrush_cnt_d = inrush_cnt_q;
		fet_d        = fet_q;
		chg_d        = chg_q;
		inr_d        = inr_q;
		if (item.op == OP_START) begin
			if (phase_q == PH_IDLE) begin
				fet_d        = 1'b0;
				chg_d        = 1'b1;
				inr_d        = 1'b1;
				inrush_cnt_d = '0;
				phase_d      = PH_OFF;
				count_d      = '0;
			end
		end else begin
			if (inr_q) begin
				inrush_cnt_d = inrush_cnt_inc;
				if (inrush_cnt_inc >= INRUSH_TICKS) begin
					inr_d        = 1'b0;
					inrush_cnt_d = '0;
				end
			end
			if (phase_q != PH_IDLE) begin
				count_d = count_inc;
				unique case (phase_q)
					PH_OFF: begin
						if (count_ext >= off_lim) begin
							chg_d   = 1'b0;
							count_d = '0;
							if (item.cut_enable) begin
								fet_d   = 1'b1;
								phase_d = cfg.iso_mode ? PH_WAIT : PH_ON;
							end else begin
								fet_d   = 1'b0;
								phase_d = PH_IDLE;
							end
						end
					end
					PH_WAIT: begin
						// ignition edge takes priority over the timeout
						if (item.trip_edge) begin
							phase_d = PH_ON;
							count_d = '0;
						end else if (count_ext >= half_lim) begin
							fet_d        = 1'b0;
							chg_d        = 1'b1;
							inr_d        = 1'b1;
							inrush_cnt_d = '0;
							phase_d      = PH_OFF;
							count_d      = '0;
						end
					end
					PH_ON: begin
						if (count_ext >= on_lim) begin
							fet_d        = 1'b0;
							chg_d        = 1'b1;
							inr_d        = 1'b1;
							inrush_cnt_d = '0;
							phase_d      = PH_OFF;
							count_d      = '0;
						end
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			count_q      <= '0;
			inrush_cnt_q <= '0;
			fet_q        <= 1'b0;
			chg_q        <= 1'b0;
			inr_q        <= 1'b0;
		end else if (step) begin
			phase_q      <= phase_d;
			count_q      <= count_d;
			inrush_cnt_q <= inrush_cnt_d;
			fet_q        <= fet_d;
			chg_q        <= chg_d;
			inr_q        <= inr_d;
		end
	end

	assign result = '{fet_on: fet_d, charger_on: chg_d, charger_inrush_limit: inr_d,
		phase: phase_d};

`ifndef SYNTHESIS
	a_idle_outputs_off: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> !fet_q && !chg_q)
		else $error("switch or charger active while idle");
	a_off_charging: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_OFF |-> chg_q && !fet_q)
		else $error("off phase without charger or with switch on");
	a_on_no_charger: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_WAIT || phase_q == PH_ON) |-> fet_q && !chg_q)
		else $error("on phase with charger running or switch off");
	a_inrush_count_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!inr_q |-> inrush_cnt_q == '0)
		else $error("inrush count left over at normal limit");
	a_hold_without_step: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(phase_q) && $stable(count_q))
		else $error("state moved without a transaction");
`endif

endmodule

// File: sv/discharge_pulse_sequencer.sv
// top level: configuration registers, input stage and result register
// an accepted item waits in stage 1 until the result register is free, then its result is registered
// throughput: one item per cycle while results are taken; phase and counters update in a single pass
// the input stage and result register let a new item in while a result waits
// reset: phase idle, counters zero, outputs off, registers on 1 / off 12 / iso mode off
module discharge_pulse_sequencer #(
	parameter int unsigned TIME_BITS = 20
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              item_valid,
	output logic              item_ready,
	input  dps_pkg::item_t    item,
	output logic              result_valid,
	input  logic              result_ready,
	output dps_pkg::result_t  result
);
	import dps_pkg::*;

	cfg_t    cfg_q;
	logic    valid_s1;
	item_t   item_s1;
	logic    advance;
	result_t next_result;
	logic    wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.on_ticks  <= 20'd1;
			cfg_q.off_ticks <= 20'd12;
			cfg_q.iso_mode  <= 1'b0;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_ON_TICKS:  cfg_q.on_ticks  <= pwdata[CFG_BITS-1:0];
				REG_OFF_TICKS: cfg_q.off_ticks <= pwdata[CFG_BITS-1:0];
				REG_ISO_MODE:  cfg_q.iso_mode  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_ON_TICKS:  prdata = 32'(cfg_q.on_ticks);
			REG_OFF_TICKS: prdata = 32'(cfg_q.off_ticks);
			REG_ISO_MODE:  prdata = 32'(cfg_q.iso_mode);
			default:       prdata = '0;
		endcase
	end

	// stage 1 hands on when the result register is free or being emptied
	assign advance    = valid_s1 && (!result_valid || result_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	dps_seq #(
		.TIME_BITS(TIME_BITS)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (next_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result <= next_result;
		end
	end

endmodule
